/* design/position_pid_antiwindup_assert.svh */
// Assertion macros used by the checker of the position PID controller.
`ifndef POSITION_PID_ANTIWINDUP_ASSERT_SVH
`define POSITION_PID_ANTIWINDUP_ASSERT_SVH

// Checked at every rising clock edge except while reset is high.
`define PPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define PPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ppa_pkg.sv */
// Package with the types and constants of the position PID controller.
`timescale 1ns / 1ps

package ppa_pkg;

   localparam int POS_W   = 24;
   localparam int ERR_W   = POS_W + 1;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int GAIN_W  = 24;
   localparam int OLIM_W  = 15;
   localparam int ILIM_W  = 20;
   localparam int SUM_W   = ILIM_W + 1;
   localparam int DRIVE_W = 16;
   localparam int FRAC_W  = 16;
   localparam int ACC_W   = 53;
   localparam int OUT_W   = ACC_W - FRAC_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP,
      CSR_KI,
      CSR_KD,
      CSR_OUTPUT_LIMIT,
      CSR_INTEGRAL_LIMIT,
      CSR_DEADBAND
   } ppa_csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
      logic [OLIM_W-1:0] output_limit;
      logic [ILIM_W-1:0] integral_limit;
      logic [OLIM_W-1:0] deadband;
   } ppa_cfg_type;

   localparam ppa_cfg_type CFG_RESET = '{
      kp:             GAIN_W'(16384),
      ki:             GAIN_W'(131),
      kd:             GAIN_W'(22938),
      output_limit:   OLIM_W'(85),
      integral_limit: ILIM_W'(12000),
      deadband:       OLIM_W'(65)
   };

   typedef struct packed {
      logic signed [POS_W-1:0] target;
      logic signed [POS_W-1:0] position;
   } ppa_sample_type;

endpackage

/* design/ppa_ifs.sv */
// Handshake interfaces for the sample and drive channels.
`timescale 1ns / 1ps

interface ppa_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [ppa_pkg::POS_W-1:0]  target;
   logic signed [ppa_pkg::POS_W-1:0]  position;

   modport source (output valid, output target, output position, input ready);
   modport sink (input valid, input target, input position, output ready);
endinterface

interface ppa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ppa_pkg::DRIVE_W-1:0]  drive;

   modport source (output valid, output drive, input ready);
   modport sink (input valid, input drive, output ready);
endinterface

/* design/ppa_csr.sv */
// Configuration register file holding the gains, limits and deadband.
`timescale 1ns / 1ps

module ppa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ppa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ppa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ppa_pkg::ppa_cfg_type               cfg
);
   import ppa_pkg::*;

   ppa_cfg_type cfg_ff;
   ppa_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KP:             cfg_in.kp = csr_wdata[GAIN_W-1:0];
            CSR_KI:             cfg_in.ki = csr_wdata[GAIN_W-1:0];
            CSR_KD:             cfg_in.kd = csr_wdata[GAIN_W-1:0];
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit = csr_wdata[OLIM_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[ILIM_W-1:0];
            CSR_DEADBAND:       cfg_in.deadband = csr_wdata[OLIM_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/ppa_core.sv */
// PID datapath with conditional integration, output clamp and deadband.
`timescale 1ns / 1ps

module ppa_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  ppa_pkg::ppa_sample_type            sample,
   input  ppa_pkg::ppa_cfg_type               cfg,
   output logic signed [ppa_pkg::DRIVE_W-1:0] drive
);
   import ppa_pkg::*;

   logic signed [ERR_W-1:0]   prev_error_ff;
   logic signed [SUM_W-1:0]   error_sum_ff;

   logic signed [ERR_W-1:0]   err;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  sum_raw;
   logic signed [DIFF_W-1:0]  ilim_pos;
   logic signed [DIFF_W-1:0]  ilim_neg;
   logic signed [SUM_W-1:0]   cand_i;
   logic signed [49:0]        p_term;
   logic signed [50:0]        d_term;
   logic signed [45:0]        i_cand;
   logic signed [45:0]        i_old;
   logic signed [ACC_W-1:0]   acc_base;
   logic signed [ACC_W-1:0]   acc_cand;
   logic signed [ACC_W-1:0]   acc_old;
   logic signed [OUT_W-1:0]   out_cand;
   logic signed [OUT_W-1:0]   out_old;
   logic signed [OUT_W-1:0]   out_sel;
   logic signed [OUT_W-1:0]   olim_pos;
   logic signed [OUT_W-1:0]   olim_neg;
   logic signed [DRIVE_W-1:0] clamped;
   logic signed [DRIVE_W-1:0] dband_pos;
   logic signed [DRIVE_W-1:0] dband_neg;
   logic                      err_neg;
   logic                      err_pos;
   logic                      commit;

   always_comb begin
      err      = ERR_W'(sample.target) - ERR_W'(sample.position);
      diff     = DIFF_W'(err) - DIFF_W'(prev_error_ff);
      err_neg  = err[ERR_W-1];
      err_pos  = !err[ERR_W-1] && (err != '0);

      // The candidate integral is clamped before it enters the gain sum.
      sum_raw  = DIFF_W'(error_sum_ff) + DIFF_W'(err);
      ilim_pos = $signed({{(DIFF_W-ILIM_W){1'b0}}, cfg.integral_limit});
      ilim_neg = -ilim_pos;
      if (sum_raw > ilim_pos) begin
         cand_i = ilim_pos[SUM_W-1:0];
      end else if (sum_raw < ilim_neg) begin
         cand_i = ilim_neg[SUM_W-1:0];
      end else begin
         cand_i = sum_raw[SUM_W-1:0];
      end

      p_term   = $signed({1'b0, cfg.kp}) * err;
      d_term   = $signed({1'b0, cfg.kd}) * diff;
      i_cand   = $signed({1'b0, cfg.ki}) * cand_i;
      i_old    = $signed({1'b0, cfg.ki}) * error_sum_ff;
      acc_base = ACC_W'(p_term) + ACC_W'(d_term);
      acc_cand = acc_base + ACC_W'(i_cand);
      acc_old  = acc_base + ACC_W'(i_old);

      // Dropping the fraction bits of a two's complement sum rounds towards minus infinity.
      out_cand = acc_cand[ACC_W-1:FRAC_W];
      out_old  = acc_old[ACC_W-1:FRAC_W];

      olim_pos = $signed({{(OUT_W-OLIM_W){1'b0}}, cfg.output_limit});
      olim_neg = -olim_pos;
      commit   = ((out_cand <= olim_pos) && (out_cand >= olim_neg)) ||
                 ((out_cand > olim_pos) && err_neg) ||
                 ((out_cand < olim_neg) && err_pos);
      out_sel  = commit ? out_cand : out_old;

      if (out_sel > olim_pos) begin
         clamped = olim_pos[DRIVE_W-1:0];
      end else if (out_sel < olim_neg) begin
         clamped = olim_neg[DRIVE_W-1:0];
      end else begin
         clamped = out_sel[DRIVE_W-1:0];
      end

      dband_pos = $signed({1'b0, cfg.deadband});
      dband_neg = -dband_pos;
      if ((clamped > 0) && (clamped < dband_pos)) begin
         drive = '0;
      end else if ((clamped < 0) && (clamped > dband_neg)) begin
         drive = '0;
      end else begin
         drive = clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (advance) begin
         prev_error_ff <= err;
         if (commit) begin
            error_sum_ff <= cand_i;
         end
      end
   end

endmodule

/* design/position_pid_antiwindup.sv */
// Top level of the position PID controller with conditional-integration anti-windup.
//
//   Channel   Direction   Handshake           Contents
//   req_chan  in          valid / ready       target, position (24-bit signed)
//   rsp_chan  out         valid / ready       drive (16-bit signed)
//   csr_*     in          write enable only   register index, write data (24 bits)
//
// One word is accepted in every cycle unless the drive stalls; it is held in the input
// register and its drive in the output register. The rate is set by the single
// combinational pass through the gain multipliers and the commit compare, which also
// updates the integral and previous error. Reset clears the handshake stages, the
// integral and previous error, and loads the default gains and limits. While the drive
// waits, the input register still takes one more word.
`timescale 1ns / 1ps

module position_pid_antiwindup (
   input  logic                            clock,
   input  logic                            reset,
   ppa_req_if.sink                         req_chan,
   ppa_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [ppa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ppa_pkg::*;

   ppa_cfg_type                cfg;
   ppa_sample_type             sample_ff;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic signed [DRIVE_W-1:0]  out_drive_ff;
   logic signed [DRIVE_W-1:0]  drive;
   logic                       accept;
   logic                       advance;

   ppa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppa_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (sample_ff),
      .cfg     (cfg),
      .drive   (drive)
   );

   always_comb begin
      advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
      req_chan.ready = !reset && (!s1_valid_ff || !out_valid_ff || rsp_chan.ready);
      accept         = req_chan.valid && req_chan.ready;
      s1_valid_in    = accept || (s1_valid_ff && !advance);
      out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff.target   <= req_chan.target;
         sample_ff.position <= req_chan.position;
      end
      if (advance) begin
         out_drive_ff <= drive;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.drive = out_drive_ff;

endmodule

/* design/ppa_checker.sv */
// Port-level checker for the position PID controller, bound to the top level.
`timescale 1ns / 1ps
`include "position_pid_antiwindup_assert.svh"

module ppa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ppa_pkg::DRIVE_W-1:0]  rsp_drive
);
   import ppa_pkg::*;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MOST_NEG = {1'b1, {(DRIVE_W-1){1'b0}}};

   `PPA_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "drive word shown after reset")
   `PPA_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "no word taken while output is empty")
   `PPA_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive), "stalled drive word changed")
   `PPA_ASSERT(a_drive_range, clock, reset, rsp_valid |-> rsp_drive != DRIVE_MOST_NEG, "drive beyond the output limit range")

endmodule

bind position_pid_antiwindup ppa_checker u_ppa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_drive (rsp_chan.drive)
);
